[rtl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0] RESET_COLOR = 8'h0F;
	localparam logic [7:0] BLANK_CHAR  = 8'h20;
	localparam logic [7:0] NL_CHAR     = 8'd10;
	localparam logic [7:0] CR_CHAR     = 8'd13;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_DRAW  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef logic [15:0] cell_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [7:0] cell_color;
		logic [7:0] column_in;
		logic [7:0] row_in;
	} item_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [10:0] cursor_pos;
		logic [15:0] read_data;
		logic        scrolled;
		logic        coord_ignored;
	} result_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL
	} state_t;

endpackage

[rtl/tcw_cell_ram.sv]
// Screen cell store: one write port, one registered read port.
module tcw_cell_ram #(
	parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  tcw_pkg::cell_t wdata,
	input  logic [AW-1:0]  raddr,
	output tcw_pkg::cell_t rdata
);

	tcw_pkg::cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/text_console_writer_core.sv]
// Text console top level: cursor, command sequencer and screen store.
// Put char without a scroll and draw cell: result in the cycle after start; a valid read cell goes through ST_READ.
// Scroll: ST_SCROLL copies each row up, then ST_FILL blanks the last row; one cell copied or blanked per cycle,
// but for a hold while the last copy drains. Clear: one cell per cycle through the single write port.
// Busy falls as done rises, so the next item can be taken in the result cycle.
// After reset busy stays high while every cell is set to 0x0F20.
module text_console_writer_core #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tcw_pkg::item_t   item,
	output logic             done,
	output tcw_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);

	localparam int CELLS     = COLUMNS * ROWS;
	localparam int AW        = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int COPY_LAST = CELLS - COLUMNS - 1;
	localparam int LAST_ROW  = CELLS - COLUMNS;

	tcw_pkg::state_t  state_q, state_d;
	logic [AW-1:0]    cnt_q, cnt_d;
	logic [RW-1:0]    row_q, row_d;
	logic [CW-1:0]    col_q, col_d;
	logic [7:0]       color_q;
	logic             done_q, done_d;
	logic             copy_s1, copy_d;
	logic [AW-1:0]    copy_addr_s1, copy_addr_d;
	tcw_pkg::result_t res_q, res_d;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	tcw_pkg::cell_t   mem_wdata;
	logic [AW-1:0]    mem_raddr;
	tcw_pkg::cell_t   mem_rdata;

	logic             coord_ok;
	logic [AW-1:0]    coord_addr;
	logic [AW-1:0]    cursor_addr;
	logic             row_inc;

	tcw_cell_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign busy      = (state_q != tcw_pkg::ST_IDLE);
	assign done      = done_q;
	assign result    = res_q;
	assign cfg_ready = 1'b1;

	assign coord_ok    = (9'(item.column_in) < 9'(COLUMNS)) && (9'(item.row_in) < 9'(ROWS));
	assign coord_addr  = AW'(int'(item.row_in) * COLUMNS + int'(item.column_in));
	assign cursor_addr = AW'(int'(row_q) * COLUMNS + int'(col_q));

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		row_d       = row_q;
		col_d       = col_q;
		res_d       = res_q;
		done_d      = 1'b0;
		copy_d      = 1'b0;
		copy_addr_d = cnt_q;
		row_inc     = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = cnt_q;
		mem_wdata   = {color_q, tcw_pkg::BLANK_CHAR};
		mem_raddr   = cnt_q;

		// retire the copy read issued last cycle
		if (copy_s1) begin
			mem_we    = 1'b1;
			mem_waddr = copy_addr_s1;
			mem_wdata = mem_rdata;
		end

		case (state_q)
			tcw_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CHAR};
				if (cnt_q == AW'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = tcw_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (start) begin
					res_d.read_data     = '0;
					res_d.scrolled      = 1'b0;
					res_d.coord_ignored = 1'b0;
					case (tcw_pkg::cmd_t'(item.cmd))
						tcw_pkg::CMD_PUT: begin
							if (item.char_code == tcw_pkg::NL_CHAR) begin
								col_d   = '0;
								row_inc = 1'b1;
							end else if (item.char_code == tcw_pkg::CR_CHAR) begin
								col_d = '0;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cursor_addr;
								mem_wdata = {color_q, item.char_code};
								if (col_q == CW'(COLUMNS - 1)) begin
									col_d   = '0;
									row_inc = 1'b1;
								end else begin
									col_d = col_q + 1'b1;
								end
							end
							if (row_inc && (row_q == RW'(ROWS - 1))) begin
								res_d.scrolled = 1'b1;
								if (ROWS > 1) begin
									cnt_d   = '0;
									state_d = tcw_pkg::ST_SCROLL;
								end else begin
									cnt_d   = AW'(LAST_ROW);
									state_d = tcw_pkg::ST_FILL;
								end
							end else begin
								if (row_inc) begin
									row_d = row_q + 1'b1;
								end
								done_d = 1'b1;
							end
						end
						tcw_pkg::CMD_DRAW: begin
							if (coord_ok) begin
								mem_we    = 1'b1;
								mem_waddr = coord_addr;
								mem_wdata = {item.cell_color, item.char_code};
							end else begin
								res_d.coord_ignored = 1'b1;
							end
							done_d = 1'b1;
						end
						tcw_pkg::CMD_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							cnt_d   = '0;
							state_d = tcw_pkg::ST_FILL;
						end
						tcw_pkg::CMD_READ: begin
							if (coord_ok) begin
								mem_raddr = coord_addr;
								state_d   = tcw_pkg::ST_READ;
							end else begin
								res_d.coord_ignored = 1'b1;
								done_d              = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
					res_d.cursor_row = 5'(row_d);
					res_d.cursor_col = 7'(col_d);
					res_d.cursor_pos = 11'(int'(row_d) * COLUMNS + int'(col_d));
				end
			end
			tcw_pkg::ST_READ: begin
				res_d.read_data = mem_rdata;
				done_d          = 1'b1;
				state_d         = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_SCROLL: begin
				// read one row below, write back next cycle
				mem_raddr   = cnt_q + AW'(COLUMNS);
				copy_d      = 1'b1;
				copy_addr_d = cnt_q;
				if (cnt_q == AW'(COPY_LAST)) begin
					cnt_d   = AW'(LAST_ROW);
					state_d = tcw_pkg::ST_FILL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tcw_pkg::ST_FILL: begin
				// hold while the last copy drains through the write port
				if (!copy_s1) begin
					mem_we    = 1'b1;
					mem_waddr = cnt_q;
					mem_wdata = {color_q, tcw_pkg::BLANK_CHAR};
					if (cnt_q == AW'(CELLS - 1)) begin
						cnt_d   = '0;
						done_d  = 1'b1;
						state_d = tcw_pkg::ST_IDLE;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
			cnt_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			color_q <= tcw_pkg::RESET_COLOR;
			done_q  <= 1'b0;
			copy_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			row_q   <= row_d;
			col_q   <= col_d;
			done_q  <= done_d;
			copy_s1 <= copy_d;
			if (cfg_valid && cfg_ready) begin
				color_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q        <= res_d;
		copy_addr_s1 <= copy_addr_d;
	end

endmodule
